// ===== rtl/bud_pkg.sv =====
`timescale 1ns / 1ps

package bud_pkg;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    typedef struct packed {
        logic        opcode;
        logic [13:0] request_size;
        logic [13:0] free_address;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [13:0] address;
        logic [3:0]  granted_order;
    } t_out_item;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_DEC,
        S_A_SCAN,
        S_A_CHK,
        S_A_CLR,
        S_S_RD,
        S_S_WR,
        S_A_FIN,
        S_F_CHK,
        S_M_RD,
        S_M_CHK,
        S_M_SWR,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        BO_FREE_SLOT,
        BO_SPLIT,
        BO_ALLOC,
        BO_MERGE
    } t_bo_sel;

    typedef enum logic [1:0] {
        RES_OK_ALLOC,
        RES_OK_FREE,
        RES_NO_SPACE,
        RES_BAD_FREE
    } t_res_sel;

    typedef struct packed {
        logic     capture;
        logic     clr_wr;
        logic     dec_alloc;
        logic     free_ld;
        logic     bo_rd;
        logic     fm_rd;
        logic     fm_scan;
        logic     scan_next;
        logic     found;
        logic     fm_wr;
        logic     fm_wval;
        logic     fm_flip;
        logic     descend;
        logic     ascend;
        logic     bo_wr;
        t_bo_sel  bo_sel;
        logic     res_ld;
        t_res_sel res_sel;
        logic     out_ld;
    } t_cmd;

    typedef struct packed {
        logic is_alloc;
        logic want_ok;
        logic pre_ok;
        logic bo_alloc;
        logic scan_hit;
        logic scan_last;
        logic ord_top;
        logic ord_eq_want;
        logic sib_free;
        logic clr_last;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/buddy_allocator.sv =====
`timescale 1ns / 1ps
// Binary buddy allocator. Requests arrive on the input channel (i_in_valid,
// o_in_stall, i_in_data) and each gives exactly one result item on the output
// channel (o_out_valid, i_out_stall, o_out_data). An allocate returns the block
// offset plus one and its order; a free returns the order of the merged block.
// Items are handled one at a time and the free map is held as 32-bit words.
// An allocate scans the free map word by word from the wanted order up until
// a free block turns up (one word for each order o of NUM_ORDERS-6 or above,
// 2^(NUM_ORDERS-6-o) words below), then splits that block down to the wanted
// order; a free that passes its checks merges with its free buddy at each
// level upward. The next item can be accepted in the cycle after a result has
// been loaded.
// After reset the block runs a clearing pass over its memories, during which
// o_in_stall stays high.
// A finished result sits in an output register. While it waits, the next item
// is accepted and worked on, but its result holds in the block, and no further
// item is accepted, until the receiver lowers i_out_stall.
module buddy_allocator #(
    parameter int NUM_ORDERS    = 10,
    parameter int MIN_BLOCK_LOG = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  bud_pkg::t_in_item  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output bud_pkg::t_out_item o_out_data
);
    import bud_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    bud_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    bud_dp #(
        .NUM_ORDERS    (NUM_ORDERS),
        .MIN_BLOCK_LOG (MIN_BLOCK_LOG)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while a request was still in progress");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == ST_OK || o_out_data.status == ST_NO_SPACE
                         || o_out_data.status == ST_BAD_FREE))
        else $error("undefined status code on output item");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK)
        |-> (o_out_data.address == 14'd0 && o_out_data.granted_order == 4'd0))
        else $error("failed request carries an address or order");

    a_no_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_out_valid)) |-> $past(o_in_stall))
        else $error("result produced without a request in progress");

endmodule

// ===== rtl/bud_ctrl.sv =====
`timescale 1ns / 1ps

module bud_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  bud_pkg::t_stat i_stat,
    output bud_pkg::t_cmd  o_cmd,
    output logic          o_in_stall
);
    import bud_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:    if (i_stat.clr_last) n_state = S_IDLE;
            S_IDLE:   if (i_in_valid) n_state = S_DEC;
            S_DEC: begin
                if (i_stat.is_alloc) begin
                    n_state = i_stat.want_ok ? S_A_SCAN : S_DONE;
                end else begin
                    n_state = i_stat.pre_ok ? S_F_CHK : S_DONE;
                end
            end
            S_A_SCAN: n_state = S_A_CHK;
            S_A_CHK: begin
                if (i_stat.scan_hit) begin
                    n_state = S_A_CLR;
                end else if (i_stat.scan_last && i_stat.ord_top) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_A_SCAN;
                end
            end
            S_A_CLR:  n_state = i_stat.ord_eq_want ? S_A_FIN : S_S_RD;
            S_S_RD:   n_state = S_S_WR;
            S_S_WR:   n_state = i_stat.ord_eq_want ? S_A_FIN : S_S_RD;
            S_A_FIN:  n_state = S_DONE;
            S_F_CHK:  n_state = i_stat.bo_alloc ? S_M_RD : S_DONE;
            S_M_RD:   n_state = S_M_CHK;
            S_M_CHK:  n_state = (!i_stat.ord_top && i_stat.sib_free) ? S_M_RD : S_M_SWR;
            S_M_SWR:  n_state = S_DONE;
            S_DONE:   if (i_stat.out_free) n_state = S_IDLE;
            default:  n_state = S_CLR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_CLR:  o_cmd.clr_wr = 1'b1;
            S_IDLE: o_cmd.capture = i_in_valid;
            S_DEC: begin
                if (i_stat.is_alloc) begin
                    if (i_stat.want_ok) begin
                        o_cmd.dec_alloc = 1'b1;
                    end else begin
                        o_cmd.res_ld  = 1'b1;
                        o_cmd.res_sel = RES_NO_SPACE;
                    end
                end else begin
                    if (i_stat.pre_ok) begin
                        o_cmd.bo_rd = 1'b1;
                    end else begin
                        o_cmd.res_ld  = 1'b1;
                        o_cmd.res_sel = RES_BAD_FREE;
                    end
                end
            end
            S_A_SCAN: begin
                o_cmd.fm_rd   = 1'b1;
                o_cmd.fm_scan = 1'b1;
            end
            S_A_CHK: begin
                if (i_stat.scan_hit) begin
                    o_cmd.found = 1'b1;
                end else if (i_stat.scan_last && i_stat.ord_top) begin
                    o_cmd.res_ld  = 1'b1;
                    o_cmd.res_sel = RES_NO_SPACE;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_A_CLR: begin
                o_cmd.fm_wr   = 1'b1;
                o_cmd.descend = !i_stat.ord_eq_want;
            end
            S_S_RD: o_cmd.fm_rd = 1'b1;
            S_S_WR: begin
                // The upper half of each split becomes a free block.
                o_cmd.fm_wr   = 1'b1;
                o_cmd.fm_wval = 1'b1;
                o_cmd.fm_flip = 1'b1;
                o_cmd.bo_wr   = 1'b1;
                o_cmd.bo_sel  = BO_SPLIT;
                o_cmd.descend = !i_stat.ord_eq_want;
            end
            S_A_FIN: begin
                o_cmd.bo_wr   = 1'b1;
                o_cmd.bo_sel  = BO_ALLOC;
                o_cmd.res_ld  = 1'b1;
                o_cmd.res_sel = RES_OK_ALLOC;
            end
            S_F_CHK: begin
                if (i_stat.bo_alloc) begin
                    o_cmd.free_ld = 1'b1;
                    o_cmd.bo_wr   = 1'b1;
                    o_cmd.bo_sel  = BO_FREE_SLOT;
                end else begin
                    o_cmd.res_ld  = 1'b1;
                    o_cmd.res_sel = RES_BAD_FREE;
                end
            end
            S_M_RD: o_cmd.fm_rd = 1'b1;
            S_M_CHK: begin
                if (!i_stat.ord_top && i_stat.sib_free) begin
                    o_cmd.fm_wr   = 1'b1;
                    o_cmd.fm_flip = 1'b1;
                    o_cmd.ascend  = 1'b1;
                end
            end
            S_M_SWR: begin
                o_cmd.fm_wr   = 1'b1;
                o_cmd.fm_wval = 1'b1;
                o_cmd.bo_wr   = 1'b1;
                o_cmd.bo_sel  = BO_MERGE;
                o_cmd.res_ld  = 1'b1;
                o_cmd.res_sel = RES_OK_FREE;
            end
            S_DONE: o_cmd.out_ld = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/bud_dp.sv =====
`timescale 1ns / 1ps

module bud_dp #(
    parameter int NUM_ORDERS    = 10,
    parameter int MIN_BLOCK_LOG = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bud_pkg::t_in_item  i_in_data,
    input  bud_pkg::t_cmd      i_cmd,
    output bud_pkg::t_stat     o_stat,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output bud_pkg::t_out_item o_out_data
);
    import bud_pkg::*;

    localparam int TOP      = NUM_ORDERS - 1;
    localparam int SLOTS    = 1 << TOP;
    localparam int SLOT_W   = TOP;
    localparam int ORD_W    = $clog2(NUM_ORDERS);
    localparam int BO_W     = ORD_W + 1;
    localparam int HEAP_W   = NUM_ORDERS;
    localparam int FW_LOG   = (NUM_ORDERS >= 5) ? 5 : NUM_ORDERS;
    localparam int FW       = 1 << FW_LOG;
    localparam int FMA_W    = (NUM_ORDERS > FW_LOG) ? NUM_ORDERS - FW_LOG : 1;
    localparam int FM_WORDS = 1 << (NUM_ORDERS - FW_LOG);

    // Heap numbering: the block at position p of order o is node 2^(TOP-o) + p.
    function automatic logic [HEAP_W-1:0] f_onehot(input logic [ORD_W-1:0] ord);
        return HEAP_W'(1) << (TOP - int'(ord));
    endfunction

    logic [FW-1:0]     fm_mem [FM_WORDS];
    logic [BO_W-1:0]   bo_mem [SLOTS];

    logic              r_op;
    logic [13:0]       r_size;
    logic [13:0]       r_faddr;
    logic [ORD_W-1:0]  r_ord;
    logic [ORD_W-1:0]  r_want;
    logic [SLOT_W-1:0] r_pos;
    logic [FMA_W-1:0]  r_widx;
    logic [SLOT_W-1:0] r_slot;
    logic [FW-1:0]     r_word;
    logic [BO_W-1:0]   r_bo;
    logic [SLOT_W-1:0] r_clr;
    t_out_item         r_res;
    t_out_item         r_out;
    logic              r_ovalid;

    logic              want_ok;
    logic [ORD_W-1:0]  want_c;
    logic [13:0]       off;
    logic [31:0]       off_sh;
    logic              pre_ok;
    logic [SLOT_W-1:0] slot_c;
    logic [HEAP_W-1:0] onehot;
    logic [HEAP_W-1:0] onehot_nx;
    logic [HEAP_W-1:0] onehot_want;
    logic [HEAP_W-1:0] hn;
    logic [HEAP_W-1:0] hn_sh;
    logic [HEAP_W-1:0] hl;
    logic [HEAP_W-1:0] hl_sh;
    logic [HEAP_W-1:0] hs_nx;
    logic [HEAP_W-1:0] hs_want;
    logic [HEAP_W-1:0] hb;
    logic [HEAP_W-1:0] hf;
    logic [FW-1:0]     masked;
    logic [FW_LOG-1:0] ffs;
    logic [FW_LOG-1:0] bidx;
    logic [FW_LOG-1:0] sidx;
    logic [ORD_W-1:0]  ord_b;
    logic [SLOT_W-1:0] slot_node;
    logic [SLOT_W-1:0] slot_split;
    logic [31:0]       a32;
    logic [31:0]       a1;
    logic              fm_we;
    logic [FMA_W-1:0]  fm_wa;
    logic [FW-1:0]     fm_wd;
    logic [FMA_W-1:0]  fm_ra;
    logic              bo_we;
    logic [SLOT_W-1:0] bo_wa;
    logic [BO_W-1:0]   bo_wd;

    always_comb begin
        want_ok = 1'b0;
        want_c  = '0;
        for (int w = 0; w < NUM_ORDERS; w++) begin
            if (!want_ok && ((32'(r_size) >> (MIN_BLOCK_LOG + w)) == 32'd0)) begin
                want_ok = 1'b1;
                want_c  = ORD_W'(w);
            end
        end
    end

    assign off    = r_faddr - 14'd1;
    assign off_sh = 32'(off) >> MIN_BLOCK_LOG;
    assign pre_ok = (r_faddr != 14'd0) && (off[MIN_BLOCK_LOG-1:0] == '0)
                    && (off_sh < 32'(SLOTS));
    assign slot_c = off_sh[SLOT_W-1:0];

    assign onehot      = f_onehot(r_ord);
    assign onehot_nx   = f_onehot(r_ord + ORD_W'(1));
    assign onehot_want = f_onehot(want_c);
    assign hn          = onehot | HEAP_W'(r_pos);
    assign hn_sh       = hn >> FW_LOG;
    assign hl          = (onehot << 1) - HEAP_W'(1);
    assign hl_sh       = hl >> FW_LOG;
    assign hs_nx       = onehot_nx >> FW_LOG;
    assign hs_want     = onehot_want >> FW_LOG;
    assign bidx        = hn[FW_LOG-1:0] ^ {{(FW_LOG-1){1'b0}}, i_cmd.fm_flip};
    assign sidx        = hn[FW_LOG-1:0] ^ {{(FW_LOG-1){1'b0}}, 1'b1};

    // Only the nodes of the order being scanned count in the word.
    always_comb begin
        hb     = '0;
        masked = '0;
        for (int b = 0; b < FW; b++) begin
            hb        = (HEAP_W'(r_widx) << FW_LOG) | HEAP_W'(b);
            masked[b] = r_word[b] && ((hb >> (TOP - int'(r_ord))) == HEAP_W'(1));
        end
    end

    always_comb begin
        ffs = '0;
        for (int b = FW - 1; b >= 0; b--) begin
            if (masked[b]) ffs = FW_LOG'(b);
        end
    end

    assign hf         = (HEAP_W'(r_widx) << FW_LOG) | HEAP_W'(ffs);
    assign ord_b      = (r_bo[ORD_W-1:0] > ORD_W'(TOP)) ? ORD_W'(TOP) : r_bo[ORD_W-1:0];
    assign slot_node  = r_pos << r_ord;
    assign slot_split = (r_pos | SLOT_W'(1)) << r_ord;
    assign a32        = 32'(slot_node) << MIN_BLOCK_LOG;
    assign a1         = a32 + 32'd1;

    always_comb begin
        fm_we = 1'b0;
        fm_wa = hn_sh[FMA_W-1:0];
        fm_wd = r_word;
        if (i_cmd.clr_wr) begin
            fm_we = (32'(r_clr) < 32'(FM_WORDS));
            fm_wa = r_clr[FMA_W-1:0];
            fm_wd = (r_clr == '0) ? FW'(2) : '0;
        end else if (i_cmd.fm_wr) begin
            fm_we       = 1'b1;
            fm_wd[bidx] = i_cmd.fm_wval;
        end
    end

    assign fm_ra = i_cmd.fm_scan ? r_widx : hn_sh[FMA_W-1:0];

    always_comb begin
        bo_we = 1'b0;
        bo_wa = slot_node;
        bo_wd = {1'b0, r_ord};
        if (i_cmd.clr_wr) begin
            bo_we = 1'b1;
            bo_wa = r_clr;
            bo_wd = (r_clr == '0) ? {1'b0, ORD_W'(TOP)} : '0;
        end else if (i_cmd.bo_wr) begin
            bo_we = 1'b1;
            case (i_cmd.bo_sel)
                BO_FREE_SLOT: begin
                    bo_wa = r_slot;
                    bo_wd = {1'b0, ord_b};
                end
                BO_SPLIT: bo_wa = slot_split;
                BO_ALLOC: bo_wd = {1'b1, r_ord};
                BO_MERGE: bo_wd = {1'b0, r_ord};
                default:  bo_we = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (fm_we) fm_mem[fm_wa] <= fm_wd;
        if (i_cmd.fm_rd) r_word <= fm_mem[fm_ra];
    end

    always_ff @(posedge i_clk) begin
        if (bo_we) bo_mem[bo_wa] <= bo_wd;
        if (i_cmd.bo_rd) r_bo <= bo_mem[slot_c];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_in_data.opcode;
            r_size  <= i_in_data.request_size;
            r_faddr <= i_in_data.free_address;
        end
        if (i_cmd.bo_rd) r_slot <= slot_c;
        if (i_cmd.dec_alloc) begin
            r_ord  <= want_c;
            r_want <= want_c;
            r_widx <= hs_want[FMA_W-1:0];
        end else if (i_cmd.scan_next) begin
            if (r_widx == hl_sh[FMA_W-1:0]) begin
                r_ord  <= r_ord + ORD_W'(1);
                r_widx <= hs_nx[FMA_W-1:0];
            end else begin
                r_widx <= r_widx + FMA_W'(1);
            end
        end else if (i_cmd.found) begin
            r_pos <= SLOT_W'(hf ^ onehot);
        end else if (i_cmd.free_ld) begin
            r_ord <= ord_b;
            r_pos <= r_slot >> ord_b;
        end else if (i_cmd.descend) begin
            r_ord <= r_ord - ORD_W'(1);
            r_pos <= r_pos << 1;
        end else if (i_cmd.ascend) begin
            r_ord <= r_ord + ORD_W'(1);
            r_pos <= r_pos >> 1;
        end
        if (i_cmd.res_ld) begin
            case (i_cmd.res_sel)
                RES_OK_ALLOC: r_res <= '{ST_OK, a1[13:0], 4'(r_ord)};
                RES_OK_FREE:  r_res <= '{ST_OK, 14'd0, 4'(r_ord)};
                RES_NO_SPACE: r_res <= '{ST_NO_SPACE, 14'd0, 4'd0};
                RES_BAD_FREE: r_res <= '{ST_BAD_FREE, 14'd0, 4'd0};
                default:      r_res <= '{ST_BAD_FREE, 14'd0, 4'd0};
            endcase
        end
        if (i_cmd.out_ld) r_out <= r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) r_clr <= r_clr + SLOT_W'(1);
            if (i_cmd.out_ld) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat             = '0;
        o_stat.is_alloc    = (r_op == OP_ALLOC);
        o_stat.want_ok     = want_ok;
        o_stat.pre_ok      = pre_ok;
        o_stat.bo_alloc    = r_bo[ORD_W];
        o_stat.scan_hit    = |masked;
        o_stat.scan_last   = (r_widx == hl_sh[FMA_W-1:0]);
        o_stat.ord_top     = (r_ord == ORD_W'(TOP));
        o_stat.ord_eq_want = (r_ord == r_want);
        o_stat.sib_free    = r_word[sidx];
        o_stat.clr_last    = &r_clr;
        o_stat.out_free    = !r_ovalid || !i_out_stall;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

// ===== tb/buddy_allocator_checker.sv =====
`timescale 1ns / 1ps

module buddy_allocator_checker #(
    parameter int NUM_ORDERS    = 10,
    parameter int MIN_BLOCK_LOG = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  bud_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  bud_pkg::t_out_item i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import bud_pkg::*;

    localparam int TOP   = NUM_ORDERS - 1;
    localparam int SLOTS = 1 << TOP;
    localparam int NODES = (1 << NUM_ORDERS) - 1;

    logic [3:0] order_at [SLOTS];
    logic       in_use   [SLOTS];
    logic       whole_free [NODES];
    t_out_item  expected_results [$];

    function automatic int node_index(int ord, int pos);
        return ((1 << (TOP - ord)) - 1) + pos;
    endfunction

    function automatic t_out_item allocate_block(logic [13:0] size);
        t_out_item r;
        int need;
        int want;
        int ord;
        int pos;
        bit hit;
        r = '0;
        need = int'(size) + 1;
        want = 0;
        pos = 0;
        while (want <= TOP && ((1 << MIN_BLOCK_LOG) << want) < need) want++;
        if (want > TOP) begin
            r.status = ST_NO_SPACE;
            return r;
        end
        ord = want;
        hit = 1'b0;
        while (ord <= TOP && !hit) begin
            for (int p = 0; p < (1 << (TOP - ord)); p++) begin
                if (whole_free[node_index(ord, p)]) begin
                    pos = p;
                    hit = 1'b1;
                    break;
                end
            end
            if (!hit) ord++;
        end
        if (!hit) begin
            r.status = ST_NO_SPACE;
            return r;
        end
        // Split down, always keeping the lower half.
        while (ord > want) begin
            whole_free[node_index(ord, pos)] = 1'b0;
            ord--;
            pos = pos << 1;
            whole_free[node_index(ord, pos)] = 1'b1;
            whole_free[node_index(ord, pos + 1)] = 1'b1;
            order_at[pos << ord] = 4'(ord);
            order_at[(pos + 1) << ord] = 4'(ord);
        end
        whole_free[node_index(want, pos)] = 1'b0;
        order_at[pos << want] = 4'(want);
        in_use[pos << want] = 1'b1;
        r.status = ST_OK;
        r.address = 14'(((pos << want) << MIN_BLOCK_LOG) + 1);
        r.granted_order = 4'(want);
        return r;
    endfunction

    function automatic t_out_item release_block(logic [13:0] addr);
        t_out_item r;
        int offs;
        int slot;
        int ord;
        int pos;
        r = '0;
        r.status = ST_BAD_FREE;
        if (addr == 0) return r;
        offs = int'(addr) - 1;
        if ((offs & ((1 << MIN_BLOCK_LOG) - 1)) != 0) return r;
        slot = offs >> MIN_BLOCK_LOG;
        if (slot >= SLOTS) return r;
        if (!in_use[slot]) return r;
        ord = int'(order_at[slot]);
        if (ord > TOP) ord = TOP;
        in_use[slot] = 1'b0;
        pos = slot >> ord;
        while (ord < TOP && whole_free[node_index(ord, pos ^ 1)]) begin
            whole_free[node_index(ord, pos ^ 1)] = 1'b0;
            pos = pos >> 1;
            ord++;
        end
        whole_free[node_index(ord, pos)] = 1'b1;
        order_at[pos << ord] = 4'(ord);
        r.status = ST_OK;
        r.granted_order = 4'(ord);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                order_at[s] = '0;
                in_use[s] = 1'b0;
            end
            for (int n = 0; n < NODES; n++) whole_free[n] = 1'b0;
            order_at[0] = 4'(TOP);
            whole_free[0] = 1'b1;
            expected_results.delete();
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result item %p", i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want != i_out_data) begin
                        if (want.status != i_out_data.status)
                            $error("status: expected %0d, got %0d",
                                   want.status, i_out_data.status);
                        if (want.address != i_out_data.address)
                            $error("address: expected %0d, got %0d",
                                   want.address, i_out_data.address);
                        if (want.granted_order != i_out_data.granted_order)
                            $error("granted_order: expected %0d, got %0d",
                                   want.granted_order, i_out_data.granted_order);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.opcode == OP_ALLOC)
                    expected_results.push_back(allocate_block(i_in_data.request_size));
                else
                    expected_results.push_back(release_block(i_in_data.free_address));
            end
            o_pending <= expected_results.size();
        end
    end
endmodule

// ===== tb/buddy_allocator_test.sv =====
`timescale 1ns / 1ps

module buddy_allocator_test;
    import bud_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_data;
    int        fail_count;
    int        pending;
    bit        calm;
    logic [13:0] live_blocks [$];

    buddy_allocator dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data)
    );

    buddy_allocator_checker checker_inst (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Track addresses handed out so that most frees hit real blocks.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall && out_data.status == ST_OK
            && out_data.address != 0)
            live_blocks.push_back(out_data.address);
    end

    initial begin
        out_stall = 1;
        forever begin
            @(posedge clk);
            out_stall <= !calm && ($urandom_range(0, 99) < 20);
        end
    end

    task automatic send_item(logic op, logic [13:0] size, logic [13:0] addr);
        t_in_item it;
        if (!calm) begin
            while ($urandom_range(0, 99) < 20) begin
                in_valid <= 0;
                @(posedge clk);
            end
        end
        it.opcode = op;
        it.request_size = size;
        it.free_address = addr;
        in_valid <= 1;
        in_data <= it;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_alloc(logic [13:0] size);
        send_item(OP_ALLOC, size, 14'($urandom));
    endtask

    task automatic send_free_live();
        int k;
        logic [13:0] a;
        if (live_blocks.size() == 0) begin
            send_item(OP_FREE, 14'($urandom), 14'd1);
            return;
        end
        k = $urandom_range(0, live_blocks.size() - 1);
        a = live_blocks[k];
        live_blocks.delete(k);
        send_item(OP_FREE, 14'($urandom), a);
    endtask

    initial begin
        int r;
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        calm = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed part.
        send_alloc(14'd0);
        send_alloc(14'd31);
        send_alloc(14'd32);
        send_alloc(14'd16383);
        send_alloc(14'd16382);
        send_alloc(14'd16383 >> 1);
        send_item(OP_FREE, 14'h3fff, 14'd0);
        send_item(OP_FREE, 14'd0, 14'd2);
        send_item(OP_FREE, 14'd0, 14'h3fff);
        send_item(OP_FREE, 14'd0, 14'd16353);
        send_item(OP_FREE, 14'd0, 14'd993);
        // Wait so the first results are known before freeing them.
        in_valid <= 0;
        do @(posedge clk); while (pending != 0);
        send_free_live();
        send_free_live();
        send_free_live();
        send_free_live();
        send_alloc(14'd16351);
        send_item(OP_FREE, 14'd0, 14'd1);
        send_item(OP_FREE, 14'd0, 14'd1);
        send_alloc(14'd100);
        send_alloc(14'd16383);

        for (int i = 0; i < 1200; i++) begin
            calm = (i >= 500 && i < 650);
            while (pending > 2) @(posedge clk);
            r = $urandom_range(0, 99);
            if (r < 45)
                send_alloc(($urandom_range(0, 9) == 0) ? 14'($urandom)
                           : 14'($urandom_range(0, 600)));
            else if (r < 90)
                send_free_live();
            else
                send_item(OP_FREE, 14'($urandom), 14'($urandom));
        end
        in_valid <= 0;
        calm = 0;
        do @(posedge clk); while (pending != 0);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end
endmodule
